/* hdl/vga_text_font_pixel_lookup_defines.svh */
// ---------------------------------------------------------------------------
// vga text font pixel lookup assertion macros
// concurrent assertion shorthands shared by the checker
// ---------------------------------------------------------------------------
`ifndef VGA_TEXT_FONT_PIXEL_LOOKUP_DEFINES_SVH
`define VGA_TEXT_FONT_PIXEL_LOOKUP_DEFINES_SVH

// property must hold at every clock edge out of reset
`define VTF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("vtf assertion failed");

// condition must never be seen out of reset
`define VTF_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("vtf forbidden condition seen");

`endif

/* hdl/vtf_pkg.sv */
// ---------------------------------------------------------------------------
// vtf_pkg
// shared types and constants of the text font pixel lookup
// ---------------------------------------------------------------------------
package vtf_pkg;

    localparam int PLANE_BYTES_DEF = 65536;
    localparam int ROWS_PER_CHAR   = 32;
    localparam int PLANE_ADDR_W    = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXTENDED_MEMORY  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARSET_A_SELECT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARSET_B_SELECT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NINE_DOT_MODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_GRAPHICS    = 3'd4;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [7:0] CHAR_GFX_MASK  = 8'hE0;
    localparam logic [7:0] CHAR_GFX_MATCH = 8'hC0;
    localparam int         ATTR_CHARSET_BIT = 3;

    typedef struct packed {
        logic                    is_write;
        logic [PLANE_ADDR_W-1:0] addr;
        logic [7:0]              data;
        logic [2:0]              bit_idx;
        logic                    blank;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

/* hdl/vtf_front.sv */
// ---------------------------------------------------------------------------
// vtf_front
// takes words, holds configuration, builds plane address and pixel select
// ---------------------------------------------------------------------------
module vtf_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               wr_en,
    input  logic [vtf_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [vtf_pkg::CFG_DATA_W-1:0]     wr_data,
    input  logic                               func,
    input  logic [15:0]                        plane_offset,
    input  logic [7:0]                         plane_data,
    input  logic [7:0]                         attribute,
    input  logic [7:0]                         character,
    input  logic [3:0]                         column,
    input  logic [4:0]                         row,
    input  vtf_pkg::fifo_stat_t                fifo_stat,
    output logic                               push,
    output vtf_pkg::item_t                     push_item
);
    import vtf_pkg::*;

    logic       ext_mem_reg;
    logic [2:0] cs_a_reg;
    logic [2:0] cs_b_reg;
    logic       nine_dot_reg;
    logic       line_gfx_reg;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    item_t      stage_item_reg;
    item_t      stage_item_next;

    logic       accept;
    logic [2:0] sel;
    logic [2:0] base_hi;
    logic       wide_col;
    logic       gfx_char;
    logic [2:0] col_eff;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_mem_reg  <= 1'b0;
            cs_a_reg     <= 3'd0;
            cs_b_reg     <= 3'd0;
            nine_dot_reg <= 1'b1;
            line_gfx_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_EXTENDED_MEMORY:  ext_mem_reg  <= wr_data[0];
                CFG_CHARSET_A_SELECT: cs_a_reg     <= wr_data[2:0];
                CFG_CHARSET_B_SELECT: cs_b_reg     <= wr_data[2:0];
                CFG_NINE_DOT_MODE:    nine_dot_reg <= wr_data[0];
                CFG_LINE_GRAPHICS:    line_gfx_reg <= wr_data[0];
                default:              ;
            endcase
        end
    end

    assign push   = stage_valid_reg && !fifo_stat.full;
    assign busy   = stage_valid_reg && fifo_stat.full;
    assign accept = start && !busy;

    always_comb
    begin
        sel      = attribute[ATTR_CHARSET_BIT] ? cs_a_reg : cs_b_reg;
        base_hi  = ext_mem_reg ? sel : 3'd0;
        wide_col = (column > 4'd7);
        gfx_char = ((character & CHAR_GFX_MASK) == CHAR_GFX_MATCH);
        col_eff  = wide_col ? 3'd7 : column[2:0];

        stage_item_next.is_write = (func == FUNC_WRITE);
        stage_item_next.addr     = (func == FUNC_WRITE) ? plane_offset
                                                        : {base_hi, character, row};
        stage_item_next.data     = plane_data;
        stage_item_next.bit_idx  = ~col_eff;
        stage_item_next.blank    = wide_col && nine_dot_reg && !(line_gfx_reg && gfx_char);

        if (accept)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_item_reg <= stage_item_next;
    end

    assign push_item = stage_item_reg;

endmodule

/* hdl/vtf_fifo.sv */
// ---------------------------------------------------------------------------
// vtf_fifo
// short queue between front and back
// ---------------------------------------------------------------------------
module vtf_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  vtf_pkg::item_t       push_item,
    input  logic                 pop,
    output vtf_pkg::item_t       pop_item,
    output vtf_pkg::fifo_stat_t  stat
);
    import vtf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == DEPTH_CNT);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hdl/vtf_back.sv */
// ---------------------------------------------------------------------------
// vtf_back
// font plane memory, byte writes and registered pixel reads
// ---------------------------------------------------------------------------
module vtf_back #(
    parameter int PLANE_BYTES = vtf_pkg::PLANE_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  vtf_pkg::fifo_stat_t fifo_stat,
    input  vtf_pkg::item_t  item,
    output logic            pop,
    output logic            done,
    output logic            pixel
);
    import vtf_pkg::*;

    localparam int ADDR_W = $clog2(PLANE_BYTES);

    logic [7:0]        plane_mem [PLANE_BYTES];
    logic [ADDR_W-1:0] addr;
    logic [7:0]        rd_data_reg;
    logic [2:0]        bit_idx_reg;
    logic              blank_reg;
    logic              valid_reg;

    // back side never stalls
    assign pop  = !fifo_stat.empty;
    assign addr = item.addr[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (pop && item.is_write)
            plane_mem[addr] <= item.data;
        rd_data_reg <= plane_mem[addr];
        bit_idx_reg <= item.bit_idx;
        blank_reg   <= item.blank;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= pop && !item.is_write;
    end

    assign done  = valid_reg;
    assign pixel = !blank_reg && rd_data_reg[bit_idx_reg];

endmodule

/* hdl/vga_text_font_pixel_lookup.sv */
// ---------------------------------------------------------------------------
// vga_text_font_pixel_lookup
// text mode character generator: font plane writes and pixel lookups
// ---------------------------------------------------------------------------
// A word is taken whenever start is high and busy is low; one word per cycle
// is sustained and busy stays low in normal use. A font write gives no
// result. A lookup gives its pixel with done high once the word has passed
// the front register, the queue, and the registered read of the single-port
// font plane memory. Results cannot be held off. PLANE_BYTES must be a power
// of two; addresses wrap at the plane size. Configuration writes belong only
// to idle periods.
module vga_text_font_pixel_lookup #(
    parameter int PLANE_BYTES = vtf_pkg::PLANE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            wr_en,
    input  logic [vtf_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [vtf_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                            func,
    input  logic [15:0]                     plane_offset,
    input  logic [7:0]                      plane_data,
    input  logic [7:0]                      attribute,
    input  logic [7:0]                      character,
    input  logic [3:0]                      column,
    input  logic [4:0]                      row,
    output logic                            done,
    output logic                            pixel
);
    import vtf_pkg::*;

    fifo_stat_t fifo_stat;
    item_t      push_item;
    item_t      pop_item;
    logic       push;
    logic       pop;

    vtf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .func         (func),
        .plane_offset (plane_offset),
        .plane_data   (plane_data),
        .attribute    (attribute),
        .character    (character),
        .column       (column),
        .row          (row),
        .fifo_stat    (fifo_stat),
        .push         (push),
        .push_item    (push_item)
    );

    vtf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    vtf_back #(
        .PLANE_BYTES (PLANE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .item      (pop_item),
        .pop       (pop),
        .done      (done),
        .pixel     (pixel)
    );

endmodule

/* hdl/vtf_checker.sv */
// ---------------------------------------------------------------------------
// vtf_checker
// port level checks of word timing for the font pixel lookup
// ---------------------------------------------------------------------------
`include "vga_text_font_pixel_lookup_defines.svh"

module vtf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic func,
    input logic done
);
    import vtf_pkg::*;

    logic take_lookup;
    logic take_write;

    assign take_lookup = start && !busy && (func == FUNC_LOOKUP);
    assign take_write  = start && !busy && (func == FUNC_WRITE);

    `VTF_ASSERT(a_lookup_gives_result, clk, rst_n, take_lookup |-> ##3 done)
    `VTF_ASSERT(a_write_gives_none, clk, rst_n, take_write |-> ##3 !done)
    `VTF_ASSERT(a_result_has_source, clk, rst_n, done |-> $past(take_lookup, 3))
    `VTF_NEVER(a_never_busy, clk, rst_n, busy)

endmodule

bind vga_text_font_pixel_lookup vtf_checker u_vtf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .func  (func),
    .done  (done)
);

/* sim/vtf_pixel_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vtf_pixel_checker
// Watches the command, configuration and result ports of the font pixel
// lookup. It keeps its own font plane and register copies, predicts every
// lookup pixel in order, and counts mismatches for the testbench top.
// ----------------------------------------------------------------------------
module vtf_pixel_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            wr_en,
    input  logic [vtf_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [vtf_pkg::CFG_DATA_W-1:0]  wr_data,
    input  logic                            func,
    input  logic [15:0]                     plane_offset,
    input  logic [7:0]                      plane_data,
    input  logic [7:0]                      attribute,
    input  logic [7:0]                      character,
    input  logic [3:0]                      column,
    input  logic [4:0]                      row,
    input  logic                            done,
    input  logic                            pixel,
    output int                              fail_count,
    output int                              pending,
    output int                              pixels_checked
);

    import vtf_pkg::*;

    typedef struct {
        logic        pix;
        logic [7:0]  ch;
        logic [3:0]  col;
        logic [4:0]  scan;
        logic [15:0] addr;
    } pixel_want_t;

    bit   [7:0]  font_store [PLANE_BYTES_DEF];
    logic        ext_mem;
    logic [2:0]  sel_a;
    logic [2:0]  sel_b;
    logic        nine_dot;
    logic        line_gfx;
    pixel_want_t pixel_q [$];
    pixel_want_t want;

    function automatic logic [15:0] glyph_addr(logic [7:0] attr, logic [7:0] ch,
                                               logic [4:0] scan);
        logic [2:0] sel;
        sel = attr[ATTR_CHARSET_BIT] ? sel_a : sel_b;
        if (!ext_mem)
        begin
            sel = 3'd0;
        end
        return {sel, 13'd0} + {3'd0, ch, 5'd0} + {11'd0, scan};
    endfunction

    function automatic logic glyph_pixel(logic [7:0] attr, logic [7:0] ch,
                                         logic [3:0] col, logic [4:0] scan);
        logic [2:0] bit_col;
        logic [7:0] glyph_row;
        bit_col = col[2:0];
        if (col > 4'd7)
        begin
            // columns past 7 repeat dot 7, but in nine-dot mode only for line graphics chars with line graphics on
            if (nine_dot && !(line_gfx && (ch & CHAR_GFX_MASK) == CHAR_GFX_MATCH))
            begin
                return 1'b0;
            end
            bit_col = 3'd7;
        end
        glyph_row = font_store[glyph_addr(attr, ch, scan)];
        return glyph_row[3'd7 - bit_col];
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_mem  = 1'b0;
            sel_a    = 3'd0;
            sel_b    = 3'd0;
            nine_dot = 1'b1;
            line_gfx = 1'b0;
            pixel_q.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pixel_q.size() == 0)
                begin
                    note_failure($sformatf("pixel %b with no lookup outstanding", pixel));
                end
                else
                begin
                    want = pixel_q.pop_front();
                    pixels_checked++;
                    if (pixel !== want.pix)
                    begin
                        note_failure($sformatf(
                            "pixel mismatch char %02h col %0d row %0d addr %04h: exp %b got %b",
                            want.ch, want.col, want.scan, want.addr, want.pix, pixel));
                    end
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    CFG_EXTENDED_MEMORY:  ext_mem  = wr_data[0];
                    CFG_CHARSET_A_SELECT: sel_a    = wr_data[2:0];
                    CFG_CHARSET_B_SELECT: sel_b    = wr_data[2:0];
                    CFG_NINE_DOT_MODE:    nine_dot = wr_data[0];
                    CFG_LINE_GRAPHICS:    line_gfx = wr_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (func == FUNC_WRITE)
                begin
                    font_store[plane_offset] = plane_data;
                end
                else
                begin
                    want.pix  = glyph_pixel(attribute, character, column, row);
                    want.ch   = character;
                    want.col  = column;
                    want.scan = row;
                    want.addr = glyph_addr(attribute, character, row);
                    pixel_q.push_back(want);
                end
            end
            pending <= pixel_q.size();
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives font plane writes and pixel lookups into the text mode character
// generator in random bursts across several register settings, with a
// checker alongside that predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_top;

    import vtf_pkg::*;

    localparam int RESET_CYCLES     = 9;
    localparam int PHASE_COUNT      = 8;
    localparam int RANDOM_PER_PHASE = 66;
    localparam int SETTLE_CYCLES    = 8;
    localparam int CYCLE_LIMIT      = 200000;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;
    logic                   func;
    logic [15:0]            plane_offset;
    logic [7:0]             plane_data;
    logic [7:0]             attribute;
    logic [7:0]             character;
    logic [3:0]             column;
    logic [4:0]             row;
    logic                   done;
    logic                   pixel;

    int fail_count;
    int pending;
    int pixels_checked;

    bit         font_written [PLANE_BYTES_DEF];
    logic       cfg_ext;
    logic [2:0] cfg_sel_a;
    logic [2:0] cfg_sel_b;
    int         burst_left;
    int         words_sent;
    int         writes_sent;
    int         lookups_sent;
    int         settings_used;
    int         cycle_count;

    vga_text_font_pixel_lookup u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .func         (func),
        .plane_offset (plane_offset),
        .plane_data   (plane_data),
        .attribute    (attribute),
        .character    (character),
        .column       (column),
        .row          (row),
        .done         (done),
        .pixel        (pixel)
    );

    vtf_pixel_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .func           (func),
        .plane_offset   (plane_offset),
        .plane_data     (plane_data),
        .attribute      (attribute),
        .character      (character),
        .column         (column),
        .row            (row),
        .done           (done),
        .pixel          (pixel),
        .fail_count     (fail_count),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus-side address of a glyph row, used to keep lookups on written bytes
    function automatic logic [15:0] font_addr_of(logic [7:0] attr, logic [7:0] ch,
                                                 logic [4:0] scan);
        logic [2:0] sel;
        sel = attr[ATTR_CHARSET_BIT] ? cfg_sel_a : cfg_sel_b;
        if (!cfg_ext)
        begin
            sel = 3'd0;
        end
        return {sel, 13'd0} + {3'd0, ch, 5'd0} + {11'd0, scan};
    endfunction

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start        <= 1'b0;
            func         <= 1'($urandom);
            plane_offset <= 16'($urandom);
            plane_data   <= 8'($urandom);
            attribute    <= 8'($urandom);
            character    <= 8'($urandom);
            column       <= 4'($urandom);
            row          <= 5'($urandom);
        end
    endtask

    task automatic send_word(logic f, logic [15:0] off, logic [7:0] dat, logic [7:0] attr,
                             logic [7:0] ch, logic [3:0] col, logic [4:0] scan);
        @(negedge clk);
        start        <= 1'b1;
        func         <= f;
        plane_offset <= off;
        plane_data   <= dat;
        attribute    <= attr;
        character    <= ch;
        column       <= col;
        row          <= scan;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (f == FUNC_WRITE)
        begin
            writes_sent++;
        end
        else
        begin
            lookups_sent++;
        end
        // bursts of random length, sometimes back to back with no gap
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                idle_cycles($urandom_range(1, 7));
            end
        end
    endtask

    task automatic font_write(logic [15:0] off, logic [7:0] dat);
        font_written[off] = 1'b1;
        send_word(FUNC_WRITE, off, dat, 8'($urandom), 8'($urandom), 4'($urandom),
                  5'($urandom));
    endtask

    task automatic pixel_lookup(logic [7:0] attr, logic [7:0] ch, logic [3:0] col,
                                logic [4:0] scan);
        send_word(FUNC_LOOKUP, 16'($urandom), 8'($urandom), attr, ch, col, scan);
    endtask

    task automatic drain();
        idle_cycles(1);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
    endtask

    // one-bit registers get random upper bits, which must be ignored
    task automatic load_setting(logic ext, logic [2:0] sel_a, logic [2:0] sel_b,
                                logic nine, logic gfx);
        logic [1:0] junk;
        drain();
        junk = 2'($urandom);
        write_reg(CFG_EXTENDED_MEMORY, {junk, ext});
        write_reg(CFG_CHARSET_A_SELECT, sel_a);
        write_reg(CFG_CHARSET_B_SELECT, sel_b);
        junk = 2'($urandom);
        write_reg(CFG_NINE_DOT_MODE, {junk, nine});
        junk = 2'($urandom);
        write_reg(CFG_LINE_GRAPHICS, {junk, gfx});
        if ($urandom_range(0, 1) == 1)
        begin
            write_reg(CFG_INDEX_W'($urandom_range(CFG_UNUSED_LOW, CFG_UNUSED_HIGH)),
                      CFG_DATA_W'($urandom));
        end
        @(negedge clk);
        wr_en    <= 1'b0;
        wr_index <= CFG_INDEX_W'($urandom);
        wr_data  <= CFG_DATA_W'($urandom);
        cfg_ext   = ext;
        cfg_sel_a = sel_a;
        cfg_sel_b = sel_b;
        settings_used++;
    endtask

    task automatic random_phase();
        logic [15:0] addr;
        logic [7:0]  attr;
        logic [7:0]  ch;
        logic [3:0]  col;
        logic [4:0]  scan;
        repeat (RANDOM_PER_PHASE)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                font_write(16'($urandom), 8'($urandom));
            end
            else
            begin
                attr = 8'($urandom);
                scan = 5'($urandom);
                case ($urandom_range(0, 5))
                    0, 1:    ch = CHAR_GFX_MATCH | 8'($urandom_range(0, 31));
                    2:       ch = $urandom_range(0, 1) ? 8'($urandom_range(8'hE0, 8'hFF))
                                                       : 8'($urandom_range(8'hA0, 8'hBF));
                    default: ch = 8'($urandom);
                endcase
                col  = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 8))
                                                   : 4'($urandom_range(9, 15));
                addr = font_addr_of(attr, ch, scan);
                // fresh byte right before the read now and then, to hit write-read hazards
                if (!font_written[addr] || $urandom_range(0, 4) == 0)
                begin
                    font_write(addr, 8'($urandom));
                end
                pixel_lookup(attr, ch, col, scan);
            end
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        func         = FUNC_WRITE;
        plane_offset = '0;
        plane_data   = '0;
        attribute    = '0;
        character    = '0;
        column       = '0;
        row          = '0;
        cfg_ext      = 1'b0;
        cfg_sel_a    = 3'd0;
        cfg_sel_b    = 3'd0;
        burst_left   = 1;
        repeat (RESET_CYCLES)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;

        // charset a at the top region, charset b in region 1, line graphics on
        load_setting(1'b1, 3'd7, 3'd1, 1'b1, 1'b1);
        font_write(16'hFFFF, 8'h01);
        pixel_lookup(8'h08, 8'hFF, 4'd7, 5'd31);
        pixel_lookup(8'hFF, 8'hFF, 4'd0, 5'd31);
        pixel_lookup(8'h08, 8'hFF, 4'd8, 5'd31);
        font_write(16'h2000, 8'h80);
        pixel_lookup(8'h00, 8'h00, 4'd0, 5'd0);
        pixel_lookup(8'hF7, 8'h00, 4'd15, 5'd0);
        font_write(16'h3800, 8'h01);
        pixel_lookup(8'h00, 8'hC0, 4'd8, 5'd0);
        pixel_lookup(8'h00, 8'hC0, 4'd12, 5'd0);
        font_write(16'h3BFF, 8'hFF);
        pixel_lookup(8'h00, 8'hDF, 4'd8, 5'd31);
        font_write(16'h3C00, 8'hFF);
        pixel_lookup(8'h00, 8'hE0, 4'd8, 5'd0);
        font_write(16'h37FF, 8'hFF);
        pixel_lookup(8'h00, 8'hBF, 4'd8, 5'd31);
        font_write(16'h0000, 8'h55);

        // base forced to zero, 8-dot cells: column 8 and above repeat column 7
        load_setting(1'b0, 3'd7, 3'd7, 1'b0, 1'b0);
        pixel_lookup(8'h00, 8'h00, 4'd8, 5'd0);
        pixel_lookup(8'h08, 8'h00, 4'd0, 5'd0);
        pixel_lookup(8'h00, 8'h00, 4'd11, 5'd0);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       load_setting(1'b0, 3'd0, 3'd0, 1'b1, 1'b0);
                1:       load_setting(1'b1, 3'd7, 3'd0, 1'b1, 1'b1);
                2:       load_setting(1'b1, 3'd0, 3'd7, 1'b0, 1'b0);
                3:       load_setting(1'b1, 3'd3, 3'd5, 1'b1, 1'b1);
                4:       load_setting(1'b0, 3'd6, 3'd2, 1'b0, 1'b1);
                5:       load_setting(1'b1, 3'd7, 3'd7, 1'b1, 1'b0);
                default: load_setting(1'($urandom), 3'($urandom), 3'($urandom),
                                      1'($urandom), 1'($urandom));
            endcase
            random_phase();
        end
        drain();

        $display("run covered %0d words (%0d font writes, %0d pixel lookups) over %0d settings",
                 words_sent, writes_sent, lookups_sent, settings_used);
        $display("%0d pixels compared, %0d mismatches", pixels_checked, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
